[hdl/edf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler package
// Word types, command codes and controller/datapath interface structs shared
// by the earliest-deadline-first tick scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

   localparam int TIME_W     = 32;
   localparam int PERIOD_W   = 16;
   localparam int BUDGET_W   = 16;
   localparam int FIRST_DL_W = 16;
   localparam int SLOT_FLD_W = 4;
   localparam int COUNT_W    = 5;

   // One quotient bit is retired per divider step.
   localparam int DIV_STEPS  = TIME_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [SLOT_FLD_W-1:0] task_slot;
      logic [PERIOD_W-1:0]   task_period;
      logic [BUDGET_W-1:0]   task_budget;
      logic [FIRST_DL_W-1:0] first_deadline;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]     tick_time;
      logic                  idle;
      logic [SLOT_FLD_W-1:0] ran_slot;
      logic                  job_done;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic div_step;
      logic load_write;
      logic scan_step;
      logic fetch;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic scan_done;
      logic out_busy;
   } ctl_stat_type;

endpackage : edf_pkg
`default_nettype wire

[hdl/edf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler controller
// Sequences a load (residue divide, table write) or a tick (slot scan,
// fetch of the picked slot, commit and result).
// ----------------------------------------------------------------------------
module edf_ctrl
   import edf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_is_tick,
   output logic              req_stall,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DIV    = 6'b000010,
      ST_LOADWR = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_COMMIT = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = (state_ff == ST_IDLE) && req_valid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               state_in = req_is_tick ? ST_SCAN : ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_LOADWR;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_LOADWR: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold here until the result register can take a new word.
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : edf_ctrl
`default_nettype wire

[hdl/edf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// EDF scheduler datapath
// Task tables, ready flags, time, release residues, the residue divider,
// the minimum-deadline scan and the result register.
// ----------------------------------------------------------------------------
module edf_datapath
   import edf_pkg::*;
#(
   parameter int MAX_TASKS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire req_type            req_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire ctl_cmd_type        cmd,
   output ctl_stat_type            stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int SLOT_W = $clog2(MAX_TASKS);
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);

   // Tables.
   logic [PERIOD_W-1:0] period_mem    [MAX_TASKS];
   logic [BUDGET_W-1:0] budget_mem    [MAX_TASKS];
   logic [BUDGET_W-1:0] remaining_mem [MAX_TASKS];
   logic [TIME_W-1:0]   deadline_mem  [MAX_TASKS];
   logic [PERIOD_W-1:0] residue_mem   [MAX_TASKS];

   logic [PERIOD_W-1:0] period_rd_ff;
   logic [BUDGET_W-1:0] budget_rd_ff;
   logic [BUDGET_W-1:0] remaining_rd_ff;
   logic [TIME_W-1:0]   deadline_rd_ff;
   logic [PERIOD_W-1:0] residue_rd_ff;
   logic [SLOT_W-1:0]   rd_addr;

   req_type                req_ff;
   logic [COUNT_W-1:0]     task_count_ff;
   logic [TIME_W-1:0]      time_ff;
   logic [MAX_TASKS-1:0]   ready_ff;
   logic [MAX_TASKS-1:0]   ready_in;
   logic [MAX_TASKS-1:0]   release_ff;

   logic [TIME_W-1:0]      div_num_ff;
   logic [PERIOD_W-1:0]    div_rem_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;
   logic [PERIOD_W:0]      div_shift;
   logic [PERIOD_W:0]      div_divisor;

   logic [CNT_W-1:0]       scan_cnt_ff;
   logic                   scan_issue;
   logic                   proc_v_ff;
   logic [SLOT_W-1:0]      proc_idx_ff;
   logic                   scan_proc;
   logic [CNT_W-1:0]       use_cnt;
   logic                   in_use;
   logic                   candidate;
   logic                   time_wrap;
   logic [PERIOD_W-1:0]    residue_new;

   logic                   found_ff;
   logic [SLOT_W-1:0]      pick_ff;
   logic [TIME_W-1:0]      best_ff;

   logic                   slot_ok;
   logic [SLOT_W-1:0]      load_addr;
   logic                   job_done;
   logic [BUDGET_W-1:0]    remaining_new;
   logic [TIME_W-1:0]      deadline_new;
   logic [MAX_TASKS-1:0]   clear_mask;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   // ---------------------------------------------------------------- control
   assign slot_ok   = (32'(req_ff.task_slot) < MAX_TASKS);
   assign load_addr = SLOT_W'(req_ff.task_slot);

   assign use_cnt = (32'(task_count_ff) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                     : CNT_W'(task_count_ff);

   assign scan_issue = (32'(scan_cnt_ff) < MAX_TASKS);
   assign scan_proc  = cmd.scan_step && proc_v_ff;
   // Outside the scan the read port stays on the picked slot, so its data
   // survives a commit that waits on the result register.
   assign rd_addr    = cmd.scan_step ? scan_cnt_ff[SLOT_W-1:0] : pick_ff;

   assign stat.div_done  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS));
   assign stat.scan_done = proc_v_ff && (proc_idx_ff == SLOT_W'(MAX_TASKS - 1));
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   // ----------------------------------------------------------- table reads
   always_ff @(posedge clock) begin
      period_rd_ff    <= period_mem[rd_addr];
      budget_rd_ff    <= budget_mem[rd_addr];
      remaining_rd_ff <= remaining_mem[rd_addr];
      deadline_rd_ff  <= deadline_mem[rd_addr];
      residue_rd_ff   <= residue_mem[rd_addr];
   end

   // ---------------------------------------------------------- scan compare
   assign in_use    = (CNT_W'(proc_idx_ff) < use_cnt);
   assign candidate = in_use && ready_ff[proc_idx_ff];
   assign time_wrap = &time_ff;

   always_comb begin
      if (time_wrap) begin
         residue_new = '0;
      end else if (({1'b0, residue_rd_ff} + 17'd1) == {1'b0, period_rd_ff}) begin
         residue_new = '0;
      end else begin
         residue_new = residue_rd_ff + 16'd1;
      end
   end

   // ----------------------------------------------------------- commit math
   assign job_done      = found_ff && (remaining_rd_ff <= 16'd1);
   assign remaining_new = job_done ? budget_rd_ff : remaining_rd_ff - 16'd1;
   assign deadline_new  = best_ff + TIME_W'(period_rd_ff);
   assign clear_mask    = job_done ? (MAX_TASKS'(1) << pick_ff) : '0;
   assign ready_in      = (ready_ff & ~clear_mask) | release_ff;

   // ----------------------------------------------------------- table writes
   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         period_mem[load_addr] <= req_ff.task_period;
         budget_mem[load_addr] <= req_ff.task_budget;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         remaining_mem[load_addr] <= req_ff.task_budget;
      end else if (cmd.commit && found_ff) begin
         remaining_mem[pick_ff] <= remaining_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         deadline_mem[load_addr] <= TIME_W'(req_ff.first_deadline);
      end else if (cmd.commit && job_done) begin
         deadline_mem[pick_ff] <= deadline_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write && slot_ok) begin
         residue_mem[load_addr] <= div_rem_ff;
      end else if (scan_proc) begin
         residue_mem[proc_idx_ff] <= residue_new;
      end
   end

   // ------------------------------------------------------ residue divider
   assign div_shift   = {div_rem_ff, div_num_ff[TIME_W-1]};
   assign div_divisor = {1'b0, req_ff.task_period};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff     <= req_data;
         div_num_ff <= time_ff;
         div_rem_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[TIME_W-2:0], 1'b0};
         if (div_shift >= div_divisor) begin
            div_rem_ff <= PERIOD_W'(div_shift - div_divisor);
         end else begin
            div_rem_ff <= PERIOD_W'(div_shift);
         end
      end
   end

   // ------------------------------------------------------ scan payload regs
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         release_ff <= '0;
      end else if (scan_proc) begin
         release_ff[proc_idx_ff] <= in_use && (period_rd_ff != '0) && (residue_new == '0);
      end
      if (cmd.scan_step) begin
         proc_idx_ff <= scan_cnt_ff[SLOT_W-1:0];
      end
      if (scan_proc && candidate && (!found_ff || (deadline_rd_ff < best_ff))) begin
         best_ff <= deadline_rd_ff;
         pick_ff <= proc_idx_ff;
      end
      if (cmd.commit) begin
         rsp_ff.tick_time <= time_ff;
         rsp_ff.idle      <= !found_ff;
         rsp_ff.ran_slot  <= found_ff ? SLOT_FLD_W'(pick_ff) : '0;
         rsp_ff.job_done  <= job_done;
      end
   end

   // --------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         time_ff       <= '0;
         ready_ff      <= '0;
         div_cnt_ff    <= '0;
         scan_cnt_ff   <= '0;
         proc_v_ff     <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end

         if (cmd.capture) begin
            div_cnt_ff  <= '0;
            scan_cnt_ff <= '0;
            proc_v_ff   <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            if (cmd.div_step) begin
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            end
            if (cmd.scan_step) begin
               proc_v_ff <= scan_issue;
               if (scan_issue) begin
                  scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
               end
            end
            if (scan_proc && candidate) begin
               found_ff <= 1'b1;
            end
         end

         if (cmd.load_write && slot_ok) begin
            ready_ff[load_addr] <= 1'b1;
         end else if (cmd.commit) begin
            ready_ff <= ready_in;
         end

         if (cmd.commit) begin
            time_ff      <= time_ff + TIME_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : edf_datapath
`default_nettype wire

[hdl/edf_tick_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// EDF tick scheduler
// Earliest-deadline-first scheduler advanced one time unit per tick word.
// ----------------------------------------------------------------------------
// Each request word is either a load, which writes one task slot (period,
// budget, first deadline) and marks it ready with a full budget, or a tick,
// which runs the ready in-use slot with the smallest deadline (ties to the
// lowest slot), advances time and releases every in-use slot whose period
// divides the new time; a tick returns one response word, a load none. One
// word is worked on at a time, and the next request is taken in the cycle
// after the previous one finishes. A load computes the slot's release
// phase, the current time modulo the period, with a one-bit-per-cycle
// restoring divider over the 32-bit time. A tick scans the task tables
// one slot per cycle through their single read port, then fetches the
// picked slot and commits it; the commit also waits while the previous
// response word is still stalled. The response sits in an output
// register, so a finished response does not block the acceptance of the
// next request. Each slot keeps a release residue that the tick scan
// advances, so no division is done per tick. The user must write the
// task_count register through csr_wr_en and csr_wr_data only while the
// block is idle; the block itself does not enforce this. Values above
// MAX_TASKS act as MAX_TASKS.
// ----------------------------------------------------------------------------
module edf_tick_scheduler
   import edf_pkg::*;
#(
   parameter int MAX_TASKS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // The controller decides what happens in each cycle; it only sees the
   // request valid, whether the word is a tick, and the datapath status.
   edf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_tick (req_data.command == CMD_TICK),
      .req_stall   (req_stall),
      .stat        (stat),
      .cmd         (cmd)
   );

   // The datapath holds all tables, time, ready flags and the response
   // register, and acts on the controller's commands and on task_count writes.
   edf_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule : edf_tick_scheduler
`default_nettype wire
